// File: rtl/moesi_coherent_cache_controller_defines.svh
// Assertion macros shared by the cache controller RTL.
`ifndef MOESI_COHERENT_CACHE_CONTROLLER_DEFINES_SVH
`define MOESI_COHERENT_CACHE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define MCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mcc_pkg.sv
// Types, constants and helpers for the MOESI cache controller.
package mcc_pkg;

	localparam int NUM_SETS    = 64;
	localparam int NUM_WAYS    = 4;
	localparam int BLOCK_BYTES = 64;

	localparam int ADDR_W = 32;
	localparam int OFF_W  = $clog2(BLOCK_BYTES);
	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int TAG_W  = ADDR_W - SET_W - OFF_W;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

	localparam logic [2:0] REQ_PRD     = 3'd0;
	localparam logic [2:0] REQ_PWR     = 3'd1;
	localparam logic [2:0] REQ_BUSRD   = 3'd2;
	localparam logic [2:0] REQ_BUSRDX  = 3'd3;
	localparam logic [2:0] REQ_BUSUPGR = 3'd4;
	localparam logic [2:0] REQ_FLUSH   = 3'd5;

	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_BUSRD   = 2'd1;
	localparam logic [1:0] OP_BUSRDX  = 2'd2;
	localparam logic [1:0] OP_BUSUPGR = 2'd3;

	typedef enum logic [2:0] {
		LS_I = 3'd0,
		LS_S = 3'd1,
		LS_E = 3'd2,
		LS_O = 3'd3,
		LS_M = 3'd4
	} line_st_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SCAN,
		SQ_UPDATE
	} seq_t;

	typedef logic [WAY_W-1:0] way_idx_t;

	typedef struct packed {
		line_st_t         st;
		way_idx_t         rank;
		logic [TAG_W-1:0] tag;
	} way_ent_t;

	typedef way_ent_t [NUM_WAYS-1:0] row_t;

	function automatic row_t reset_row();
		row_t r;
		for (int w = 0; w < NUM_WAYS; w++) begin
			r[w].st   = LS_I;
			r[w].rank = WAY_W'(w);
			r[w].tag  = '0;
		end
		return r;
	endfunction

endpackage

// File: rtl/mcc_ram.sv
// Generic single-port-write, registered-read RAM.
module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/moesi_coherent_cache_controller.sv
// Top level of the MOESI private cache controller: sequencer, way scan and state update.
// A transaction runs through accept, scan and update: the accept edge reads the set's
// row of tags, states and LRU ranks from the row RAM, then a single tag/rank compare
// unit walks the ways one per cycle to find the hit way, the first invalid way and the
// least recently used way, and a final update step writes the updated row back and
// loads the result register. The input stalls from acceptance until the result is
// loaded, so a new transaction is taken only after the previous one has finished its
// update; a result held by out_stall keeps the update step waiting. A new transaction
// is accepted while the previous result still waits at the output. Set-level valid
// flops stand in for the reset of line states and LRU order, so no clearing pass runs
// after reset.
`include "moesi_coherent_cache_controller_defines.svh"

module moesi_coherent_cache_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] addr,
	input  logic        copies_exist,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [1:0]  bus_op,
	output logic        flushed,
	output logic [2:0]  next_state,
	output logic        writeback,
	output logic [31:0] victim_addr
);

	import mcc_pkg::*;

	seq_t state_q, state_d;

	logic             in_accept;
	logic             out_free;
	logic             ram_re;
	logic             ram_we;
	logic [SET_W-1:0] in_set;
	logic [TAG_W-1:0] in_tag;

	logic [2:0]       req_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic             copies_q;
	way_idx_t         way_q;

	logic [NUM_SETS-1:0] rvalid_q;
	row_t                ram_rdata;
	row_t                eff_row;
	row_t                new_row;

	logic     hit_found_q, inv_found_q;
	way_idx_t hit_way_q, inv_way_q, lru_way_q, lru_rank_q;

	way_ent_t cur;
	logic     first_way, hf, inf, tag_match, rank_gt;

	way_idx_t         tw;
	way_ent_t         old;
	line_st_t         cs;
	logic             is_proc, is_snoop;
	logic             r_hit, r_fl, r_wb;
	logic [1:0]       r_bus;
	line_st_t         r_nst;
	logic [ADDR_W-1:0] r_va;

	logic              out_valid_q;
	logic              hit_q, flushed_q, writeback_q;
	logic [1:0]        bus_op_q;
	line_st_t          next_state_q;
	logic [ADDR_W-1:0] victim_addr_q;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_set    = addr[OFF_W +: SET_W];
	assign in_tag    = addr[ADDR_W-1 -: TAG_W];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (in_accept) begin
					state_d = SQ_SCAN;
				end
			end
			SQ_SCAN: begin
				if (way_q == WAY_W'(NUM_WAYS - 1)) begin
					state_d = SQ_UPDATE;
				end
			end
			SQ_UPDATE: begin
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != SQ_IDLE);
		ram_re   = in_accept;
		ram_we   = (state_q == SQ_UPDATE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	mcc_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(NUM_SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(set_q),
		.wdata(new_row),
		.re   (ram_re),
		.raddr(in_set),
		.rdata(ram_rdata)
	);

	assign eff_row = rvalid_q[set_q] ? ram_rdata : reset_row();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
		end else if (ram_we) begin
			rvalid_q[set_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q    <= req_type;
			set_q    <= in_set;
			tag_q    <= in_tag;
			copies_q <= copies_exist;
		end
	end

	always_comb begin
		cur       = eff_row[way_q];
		first_way = (way_q == '0);
		hf        = first_way ? 1'b0 : hit_found_q;
		inf       = first_way ? 1'b0 : inv_found_q;
		tag_match = (cur.st != LS_I) && (cur.tag == tag_q);
		rank_gt   = (cur.rank > lru_rank_q);
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			way_q <= '0;
		end else if (state_q == SQ_SCAN) begin
			way_q       <= way_q + 1'b1;
			hit_found_q <= hf || tag_match;
			inv_found_q <= inf || (cur.st == LS_I);
			if (!hf && tag_match) begin
				hit_way_q <= way_q;
			end
			if (!inf && (cur.st == LS_I)) begin
				inv_way_q <= way_q;
			end
			if (first_way || rank_gt) begin
				lru_way_q  <= way_q;
				lru_rank_q <= cur.rank;
			end
		end
	end

	always_comb begin
		tw       = hit_found_q ? hit_way_q : (inv_found_q ? inv_way_q : lru_way_q);
		old      = eff_row[tw];
		cs       = old.st;
		is_proc  = (req_q == REQ_PRD) || (req_q == REQ_PWR);
		is_snoop = (req_q >= REQ_BUSRD) && (req_q <= REQ_FLUSH);
		new_row  = eff_row;
		r_hit    = 1'b0;
		r_bus    = OP_NONE;
		r_fl     = 1'b0;
		r_nst    = LS_I;
		r_wb     = 1'b0;
		r_va     = '0;
		if (is_proc) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (eff_row[w].rank < old.rank) begin
					new_row[w].rank = eff_row[w].rank + 1'b1;
				end
			end
			new_row[tw].rank = '0;
			if (hit_found_q) begin
				r_hit = 1'b1;
				if (req_q == REQ_PWR) begin
					if ((cs == LS_S) || (cs == LS_O)) begin
						r_bus = OP_BUSUPGR;
					end
					cs = LS_M;
				end
			end else begin
				if ((old.st == LS_M) || (old.st == LS_O)) begin
					r_wb = 1'b1;
					r_va = {old.tag, set_q, {OFF_W{1'b0}}};
				end
				new_row[tw].tag = tag_q;
				if (req_q == REQ_PWR) begin
					cs    = LS_M;
					r_bus = OP_BUSRDX;
				end else begin
					cs    = copies_q ? LS_S : LS_E;
					r_bus = OP_BUSRD;
				end
			end
			new_row[tw].st = cs;
			r_nst          = cs;
		end else if (is_snoop && hit_found_q) begin
			r_hit = 1'b1;
			priority case (req_q)
				REQ_BUSRD: begin
					if (cs == LS_M) begin
						cs   = LS_O;
						r_fl = 1'b1;
					end else if (cs == LS_E) begin
						cs   = LS_S;
						r_fl = 1'b1;
					end else if (cs == LS_O) begin
						r_fl = 1'b1;
					end
				end
				REQ_BUSRDX: begin
					r_fl = (cs == LS_M) || (cs == LS_O);
					cs   = LS_I;
				end
				REQ_BUSUPGR: begin
					if (cs == LS_M) begin
						r_fl = 1'b1;
						cs   = LS_I;
					end else if ((cs == LS_S) || (cs == LS_O)) begin
						cs = LS_I;
					end
				end
				default: begin
				end
			endcase
			new_row[tw].st = cs;
			r_nst          = cs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ram_we) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			hit_q         <= r_hit;
			bus_op_q      <= r_bus;
			flushed_q     <= r_fl;
			next_state_q  <= r_nst;
			writeback_q   <= r_wb;
			victim_addr_q <= r_va;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign bus_op      = bus_op_q;
	assign flushed     = flushed_q;
	assign next_state  = next_state_q;
	assign writeback   = writeback_q;
	assign victim_addr = victim_addr_q;

	`MCC_ASSERT_NEXT(a_accept_starts_scan, in_accept, (state_q == SQ_SCAN) && (way_q == '0), "scan did not start at way zero after accept")
	`MCC_ASSERT_NEXT(a_write_loads_result, ram_we, out_valid_q, "row write without a result")
	`MCC_ASSERT_NOW(a_wb_only_on_fill, out_valid_q && writeback_q, !hit_q && ((bus_op_q == OP_BUSRD) || (bus_op_q == OP_BUSRDX)), "writeback outside a fill")
	`MCC_ASSERT_NOW(a_flush_only_on_snoop_hit, out_valid_q && flushed_q, hit_q && (bus_op_q == OP_NONE), "flush without a snoop hit")
	`MCC_ASSERT_NOW(a_hit_way_valid, (state_q == SQ_UPDATE) && hit_found_q, eff_row[hit_way_q].st != LS_I, "hit way holds an invalid line")

endmodule

// File: test/moesi_coherent_cache_controller_test.sv
// Self-checking testbench for the MOESI cache controller, with a line-state predictor.
`timescale 1ns / 100ps

module moesi_coherent_cache_controller_test;
	import mcc_pkg::*;

	localparam int LINES = NUM_SETS * NUM_WAYS;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 4 * (NUM_WAYS + 2);
	localparam logic [2:0] REQ_RSVD_LO = 3'd6;
	localparam logic [2:0] REQ_RSVD_HI = 3'd7;

	typedef struct packed {
		logic        hit;
		logic [1:0]  bus_op;
		logic        flushed;
		logic [2:0]  next_state;
		logic        writeback;
		logic [31:0] victim_addr;
	} resp_t;

	typedef struct packed {
		logic [2:0]  req;
		logic [31:0] a;
		logic        cp;
		logic        fixed;
		resp_t       want;
	} stim_t;

	localparam resp_t RESP_NONE = '0;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [31:0] addr;
	logic        copies_exist;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [1:0]  bus_op;
	logic        flushed;
	logic [2:0]  next_state;
	logic        writeback;
	logic [31:0] victim_addr;

	line_st_t         mirror_st   [LINES];
	logic [TAG_W-1:0] mirror_tag  [LINES];
	way_idx_t         mirror_rank [LINES];

	resp_t            pending_resp [$];
	stim_t            script [$];
	logic [TAG_W-1:0] tag_pool [6];

	int mismatches;
	int idle_pct;
	int stall_pct;
	int hold_left;
	int quiet_cycles;

	moesi_coherent_cache_controller DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.addr         (addr),
		.copies_exist (copies_exist),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.bus_op       (bus_op),
		.flushed      (flushed),
		.next_state   (next_state),
		.writeback    (writeback),
		.victim_addr  (victim_addr)
	);

	always #2 clk = ~clk;

	function automatic void promote_way(int base, int way);
		way_idx_t old;
		old = mirror_rank[base + way];
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (mirror_rank[base + w] < old)
				mirror_rank[base + w] = mirror_rank[base + w] + 1'b1;
		end
		mirror_rank[base + way] = '0;
	endfunction

	function automatic resp_t resolve_access(logic [2:0] req, logic [31:0] a, logic cp);
		resp_t            r;
		int               set_i;
		int               base;
		int               way;
		int               vic;
		int               idx;
		logic [TAG_W-1:0] tg;
		line_st_t         cs;
		r = '0;
		if (req > REQ_FLUSH)
			return r;
		set_i = int'(a[OFF_W +: SET_W]);
		tg = a[ADDR_W-1 -: TAG_W];
		base = set_i * NUM_WAYS;
		way = -1;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (mirror_st[base + w] != LS_I && mirror_tag[base + w] == tg)
				way = w;
		end
		if (req == REQ_PRD || req == REQ_PWR) begin
			if (way < 0) begin
				vic = -1;
				for (int w = NUM_WAYS - 1; w >= 0; w--) begin
					if (mirror_st[base + w] == LS_I)
						vic = w;
				end
				if (vic < 0) begin
					vic = 0;
					for (int w = 1; w < NUM_WAYS; w++) begin
						if (mirror_rank[base + w] > mirror_rank[base + vic])
							vic = w;
					end
				end
				idx = base + vic;
				if (mirror_st[idx] == LS_M || mirror_st[idx] == LS_O) begin
					r.writeback = 1'b1;
					r.victim_addr = {mirror_tag[idx], SET_W'(set_i), {OFF_W{1'b0}}};
				end
				mirror_tag[idx] = tg;
				if (req == REQ_PWR) begin
					cs = LS_M;
					r.bus_op = OP_BUSRDX;
				end else begin
					cs = cp ? LS_S : LS_E;
					r.bus_op = OP_BUSRD;
				end
				mirror_st[idx] = cs;
				promote_way(base, vic);
			end else begin
				idx = base + way;
				cs = mirror_st[idx];
				r.hit = 1'b1;
				promote_way(base, way);
				if (req == REQ_PWR) begin
					if (cs == LS_S || cs == LS_O)
						r.bus_op = OP_BUSUPGR;
					cs = LS_M;
				end
				mirror_st[idx] = cs;
			end
			r.next_state = cs;
		end else if (way >= 0) begin
			idx = base + way;
			cs = mirror_st[idx];
			r.hit = 1'b1;
			case (req)
				REQ_BUSRD: begin
					if (cs == LS_M) begin
						cs = LS_O;
						r.flushed = 1'b1;
					end else if (cs == LS_E) begin
						cs = LS_S;
						r.flushed = 1'b1;
					end else if (cs == LS_O) begin
						r.flushed = 1'b1;
					end
				end
				REQ_BUSRDX: begin
					if (cs == LS_M || cs == LS_O)
						r.flushed = 1'b1;
					cs = LS_I;
				end
				REQ_BUSUPGR: begin
					if (cs == LS_M) begin
						r.flushed = 1'b1;
						cs = LS_I;
					end else if (cs == LS_S || cs == LS_O) begin
						cs = LS_I;
					end
				end
				default: begin
				end
			endcase
			mirror_st[idx] = cs;
			r.next_state = cs;
		end
		return r;
	endfunction

	function automatic stim_t mk(logic [2:0] req, logic [31:0] a, logic cp, logic fixed,
			resp_t want);
		stim_t s;
		s.req = req;
		s.a = a;
		s.cp = cp;
		s.fixed = fixed;
		s.want = want;
		return s;
	endfunction

	function automatic logic [31:0] blk(logic [TAG_W-1:0] tg, logic [SET_W-1:0] set_i);
		return {tg, set_i, {OFF_W{1'b0}}};
	endfunction

	function automatic stim_t rand_item();
		stim_t            s;
		int               roll;
		logic [SET_W-1:0] set_i;
		s = '0;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			s.req = REQ_PRD;
		else if (roll < 55)
			s.req = REQ_PWR;
		else if (roll < 67)
			s.req = REQ_BUSRD;
		else if (roll < 79)
			s.req = REQ_BUSRDX;
		else if (roll < 89)
			s.req = REQ_BUSUPGR;
		else if (roll < 96)
			s.req = REQ_FLUSH;
		else if (roll < 98)
			s.req = REQ_RSVD_LO;
		else
			s.req = REQ_RSVD_HI;
		if ($urandom_range(0, 9) == 0) begin
			s.a = $urandom();
		end else begin
			if ($urandom_range(0, 4) == 0) begin
				set_i = SET_W'($urandom());
			end else begin
				set_i = SET_W'($urandom_range(0, 3));
				if (set_i == SET_W'(3))
					set_i = '1;
			end
			s.a = {tag_pool[$urandom_range(0, 5)], set_i, OFF_W'($urandom())};
		end
		s.cp = 1'($urandom_range(0, 1));
		return s;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch in %s at %0t: got %h, want %h", what, $realtime, got, want);
		mismatches++;
	endtask

	task automatic offer(stim_t s);
		resp_t p;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= s.req;
		addr <= s.a;
		copies_exist <= s.cp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		p = resolve_access(s.req, s.a, s.cp);
		pending_resp.push_back(s.fixed ? s.want : p);
	endtask

	task automatic run_phase(int sender_idle, int recv_stall, int count, bit squeeze);
		idle_pct = sender_idle;
		stall_pct = recv_stall;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 6; i++)
			tag_pool[i] = TAG_W'($urandom());
		if (squeeze)
			hold_left <= 300;
		repeat (count)
			offer(rand_item());
	endtask

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		resp_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_resp.size() == 0) begin
				flag_mismatch("unexpected transaction", {31'b0, hit}, 32'h0);
			end else begin
				w = pending_resp.pop_front();
				if (hit !== w.hit)
					flag_mismatch("hit", {31'b0, hit}, {31'b0, w.hit});
				if (bus_op !== w.bus_op)
					flag_mismatch("bus_op", {30'b0, bus_op}, {30'b0, w.bus_op});
				if (flushed !== w.flushed)
					flag_mismatch("flushed", {31'b0, flushed}, {31'b0, w.flushed});
				if (next_state !== w.next_state)
					flag_mismatch("next_state", {29'b0, next_state}, {29'b0, w.next_state});
				if (writeback !== w.writeback)
					flag_mismatch("writeback", {31'b0, writeback}, {31'b0, w.writeback});
				if (victim_addr !== w.victim_addr)
					flag_mismatch("victim_addr", victim_addr, w.victim_addr);
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = '0;
		addr = '0;
		copies_exist = 1'b0;
		out_stall = 1'b0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		for (int i = 0; i < LINES; i++) begin
			mirror_st[i] = LS_I;
			mirror_tag[i] = '0;
			mirror_rank[i] = way_idx_t'(i % NUM_WAYS);
		end

		script.push_back(mk(REQ_PRD, 32'h0, 1'b0, 1'b1,
			resp_t'{1'b0, OP_BUSRD, 1'b0, 3'(LS_E), 1'b0, 32'h0}));
		script.push_back(mk(REQ_PRD, 32'h0, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PWR, 32'h0, 1'b1, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSRD, 32'h0, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PWR, 32'h0, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSUPGR, 32'h0, 1'b1, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSRDX, 32'h0, 1'b0, 1'b1, RESP_NONE));
		script.push_back(mk(REQ_RSVD_LO, 32'hFFFF_FFFF, 1'b1, 1'b1, RESP_NONE));
		script.push_back(mk(REQ_RSVD_HI, 32'h0, 1'b0, 1'b1, RESP_NONE));
		script.push_back(mk(REQ_PRD, 32'hFFFF_FFFF, 1'b1, 1'b1,
			resp_t'{1'b0, OP_BUSRD, 1'b0, 3'(LS_S), 1'b0, 32'h0}));
		script.push_back(mk(REQ_BUSRD, 32'hFFFF_FFFF, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PWR, 32'hFFFF_FFFF, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PWR, blk(TAG_W'(1), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PWR, blk(TAG_W'(2), '1), 1'b1, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PWR, blk(TAG_W'(3), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PRD, blk(TAG_W'(4), '1), 1'b0, 1'b1,
			resp_t'{1'b0, OP_BUSRD, 1'b0, 3'(LS_E), 1'b1, 32'hFFFF_FFC0}));
		script.push_back(mk(REQ_FLUSH, blk(TAG_W'(1), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSRDX, blk(TAG_W'(2), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSRD, blk(TAG_W'(3), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PRD, blk(TAG_W'(5), '1), 1'b1, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PRD, blk(TAG_W'(6), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PRD, blk(TAG_W'(7), '1), 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_PRD, 32'h40, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSUPGR, 32'h40, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSRD, 32'h40, 1'b0, 1'b0, RESP_NONE));
		script.push_back(mk(REQ_BUSUPGR, 32'h40, 1'b0, 1'b0, RESP_NONE));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			offer(script[i]);

		run_phase(0, 0, 490, 1'b1);
		run_phase(74, 0, 490, 1'b0);
		run_phase(0, 74, 490, 1'b0);
		run_phase(14, 14, 490, 1'b0);
		in_valid <= 1'b0;

		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
